/* hw/rtl/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg: shared definitions for the byte ring FIFO
// Operation and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int CAP_W         = 9;
    localparam int CAP_RESET     = 256;
    localparam int BYTE_W        = 8;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 3'd0,
        FUNC_POP   = 3'd1,
        FUNC_PEEK  = 3'd2,
        FUNC_GET   = 3'd3,
        FUNC_DROP  = 3'd4,
        FUNC_RESET = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_OVERFLOW   = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_NOW_EMPTY  = 3'd4,
        ST_OFFSET_ERR = 3'd5
    } status_t;

endpackage

/* hw/rtl/brf_ram.sv */
// ----------------------------------------------------------------------------
// brf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while idle.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/byte_ring_fifo_core.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_core: byte FIFO in a ring store with a programmable capacity
// Push, pop, peek, get at offset, drop n and reset, one result per request.
// ----------------------------------------------------------------------------
// Each request on the s_ channel returns one result on the m_ channel, in
// order. The block takes one request per cycle unless the m_ channel
// holds results back. The store read and the request's status are
// registered at the accepting edge; the output register loads them when
// it is free or its result is taken. Pointers and fill count live in
// registers and are updated as the request is accepted, so a push is
// written to the store at that same edge and any later read already sees
// it. The byte store is one RAM with a registered read port. Writing the
// capacity register empties the FIFO; capacity 0 acts as 1 and values
// above DEPTH act as DEPTH. No clearing pass is needed after reset.
module byte_ring_fifo_core #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: capacity
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] push_byte, [15:8] offset, [24:16] drop_count
    input  logic [2:0]  s_tuser,   // [2:0] func
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] read_byte, [16:8] fill_count
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int CAP_W = brf_pkg::CAP_W;
    localparam int BW    = brf_pkg::BYTE_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = ((AW > CAP_W) ? AW : CAP_W) + 1;

    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide == 32'd0) begin
            return CAP_W'(1);
        end else if (wide > 32'(DEPTH)) begin
            return CAP_W'(DEPTH);
        end
        return v;
    endfunction

    // ---------------- state ----------------
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [CAP_W-1:0] held_reg, held_next;
    logic [AW-1:0]    oldest_reg, oldest_next;
    logic [AW-1:0]    free_reg, free_next;

    logic                       p1_valid_reg;
    brf_pkg::status_t           p1_status_reg, p1_status_next;
    logic [CAP_W-1:0]           p1_count_reg;
    logic                       p1_rd_reg, p1_rd_next;

    logic                       out_valid_reg;
    brf_pkg::status_t           out_status_reg;
    logic [BW-1:0]              out_byte_reg;
    logic [CAP_W-1:0]           out_count_reg;

    // ---------------- request fields ----------------
    brf_pkg::func_t   func;
    logic [BW-1:0]    push_byte;
    logic [BW-1:0]    offset;
    logic [CAP_W-1:0] drop_count;

    assign func       = brf_pkg::func_t'(s_tuser[2:0]);
    assign push_byte  = s_tdata[7:0];
    assign offset     = s_tdata[15:8];
    assign drop_count = s_tdata[24:16];

    // ---------------- handshake ----------------
    logic in_acc, p1_adv;

    assign cfg_ready = 1'b1;
    assign p1_adv    = !out_valid_reg || m_tready;
    assign s_tready  = !p1_valid_reg || p1_adv;
    assign in_acc    = s_tvalid && s_tready;

    // ---------------- RAM ----------------
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [BW-1:0] ram_rdata;

    brf_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- operation logic ----------------
    logic [SW-1:0] cap_w, held_w, old_w, free_w, off_w, drop_w;
    logic [SW-1:0] old_inc, free_inc, sum_off, sum_drop;
    logic [SW-1:0] get_pos, drop_pos;

    assign cap_w    = SW'(cap_reg);
    assign held_w   = SW'(held_reg);
    assign old_w    = SW'(oldest_reg);
    assign free_w   = SW'(free_reg);
    assign off_w    = SW'(offset);
    assign drop_w   = SW'(drop_count);
    assign old_inc  = old_w + SW'(1);
    assign free_inc = free_w + SW'(1);
    assign sum_off  = old_w + off_w;
    assign sum_drop = old_w + drop_w;
    // sums stay below twice the capacity: one subtract wraps them
    assign get_pos  = (sum_off >= cap_w) ? (sum_off - cap_w) : sum_off;
    assign drop_pos = (sum_drop >= cap_w) ? (sum_drop - cap_w) : sum_drop;

    always_comb begin
        held_next      = held_reg;
        oldest_next    = oldest_reg;
        free_next      = free_reg;
        p1_status_next = brf_pkg::ST_OK;
        p1_rd_next     = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = free_reg;
        ram_raddr      = oldest_reg;

        case (func)
            brf_pkg::FUNC_PUSH: begin
                if (held_w >= cap_w) begin
                    p1_status_next = brf_pkg::ST_OVERFLOW;
                end else begin
                    ram_we    = in_acc;
                    free_next = (free_inc >= cap_w) ? '0 : free_inc[AW-1:0];
                    held_next = held_reg + CAP_W'(1);
                    if (held_w + SW'(1) == cap_w) begin
                        p1_status_next = brf_pkg::ST_FULL;
                    end
                end
            end
            brf_pkg::FUNC_POP: begin
                if (held_reg == '0) begin
                    p1_status_next = brf_pkg::ST_EMPTY;
                end else begin
                    ram_re      = in_acc;
                    p1_rd_next  = 1'b1;
                    oldest_next = (old_inc >= cap_w) ? '0 : old_inc[AW-1:0];
                    held_next   = held_reg - CAP_W'(1);
                    if (held_reg == CAP_W'(1)) begin
                        p1_status_next = brf_pkg::ST_NOW_EMPTY;
                    end
                end
            end
            brf_pkg::FUNC_PEEK: begin
                if (held_reg == '0) begin
                    p1_status_next = brf_pkg::ST_EMPTY;
                end else begin
                    ram_re     = in_acc;
                    p1_rd_next = 1'b1;
                end
            end
            brf_pkg::FUNC_GET: begin
                if (held_reg == '0) begin
                    p1_status_next = brf_pkg::ST_EMPTY;
                end else if (off_w >= held_w) begin
                    p1_status_next = brf_pkg::ST_OFFSET_ERR;
                end else begin
                    ram_re     = in_acc;
                    ram_raddr  = get_pos[AW-1:0];
                    p1_rd_next = 1'b1;
                end
            end
            brf_pkg::FUNC_DROP: begin
                if (held_reg != '0) begin
                    if (drop_w >= held_w) begin
                        oldest_next = free_reg;
                        held_next   = '0;
                    end else begin
                        oldest_next = drop_pos[AW-1:0];
                        held_next   = held_reg - drop_count;
                    end
                end
            end
            brf_pkg::FUNC_RESET: begin
                oldest_next = '0;
                free_next   = '0;
                held_next   = '0;
            end
            default: begin
            end
        endcase
    end

    assign cap_next = clamp_cap(cfg_data);

    // ---------------- pointer and count registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= clamp_cap(CAP_W'(brf_pkg::CAP_RESET));
            held_reg   <= '0;
            oldest_reg <= '0;
            free_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            // new capacity empties the ring
            cap_reg    <= cap_next;
            held_reg   <= '0;
            oldest_reg <= '0;
            free_reg   <= '0;
        end else if (in_acc) begin
            held_reg   <= held_next;
            oldest_reg <= oldest_next;
            free_reg   <= free_next;
        end
    end

    // ---------------- read stage and output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            p1_status_reg <= p1_status_next;
            p1_count_reg  <= held_next;
            p1_rd_reg     <= p1_rd_next;
        end
        if (p1_adv && p1_valid_reg) begin
            out_status_reg <= p1_status_reg;
            out_count_reg  <= p1_count_reg;
            out_byte_reg   <= p1_rd_reg ? ram_rdata : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_count_reg, out_byte_reg};

    // ---------------- assertions ----------------
    a_held_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= cap_reg)
        else $error("fill count above capacity");

    a_ptr_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (old_w < cap_w) && (free_w < cap_w))
        else $error("ring pointer beyond capacity");

    a_ptr_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg == '0 || held_reg == cap_reg) |-> (oldest_reg == free_reg))
        else $error("pointers disagree with empty or full ring");

    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("store read and written by one item");

    a_hold_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_adv) |-> !ram_re)
        else $error("store read issued while read data is still pending");

endmodule

/* test/byte_ring_fifo_core_tb.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_core_tb: self-checking bench for the byte ring FIFO core
// A short table of requests, then random request sequences, runs through
// several capacity settings while both stream sides idle at random in most
// phases. A FIFO mirror or a typed table row predicts each result, and a
// scoreboard checks each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module byte_ring_fifo_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int DEPTH    = brf_pkg::DEPTH_DEFAULT;
    localparam int DIR_ROWS = 31;

    // func codes with no operation behind them
    localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        status_t     status;
        logic [7:0]  read_byte;
        logic [8:0]  fill_count;
    } fifo_result_t;

    // drop_count holds the capacity on a config row
    typedef struct {
        row_kind_t   kind;
        logic [2:0]  func;
        logic [7:0]  push_byte;
        logic [7:0]  offset;
        logic [8:0]  drop_count;
        bit          typed;
        status_t     status;
        logic [7:0]  read_byte;
        logic [8:0]  fill_count;
    } dir_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [7:0] push_byte, [15:8] offset, [24:16] drop_count
    logic [2:0]  s_tuser   = '0;   // [2:0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [7:0] read_byte, [16:8] fill_count
    logic [2:0]  m_tuser;          // [2:0] status

    fifo_result_t results_due [$];
    dir_row_t     dir_table [DIR_ROWS];
    int           errors = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           stall_go = 1'b0;

    // mirror of the FIFO state
    logic [7:0]   mirror_mem [DEPTH];
    int unsigned  rd_pos, wr_pos, level, cap_reg;

    byte_ring_fifo_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned cap_now();
        if (cap_reg == 0) return 1;
        if (cap_reg > DEPTH) return DEPTH;
        return cap_reg;
    endfunction

    function automatic void mirror_empty();
        rd_pos = 0;
        wr_pos = 0;
        level  = 0;
    endfunction

    function automatic fifo_result_t fifo_apply(input logic [2:0] f, input logic [7:0] pb,
                                                input logic [7:0] off, input logic [8:0] nd);
        fifo_result_t r;
        int unsigned  cap;
        cap         = cap_now();
        r.status    = ST_OK;
        r.read_byte = 8'h00;
        case (f)
            FUNC_PUSH: begin
                if (level >= cap) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    mirror_mem[wr_pos % DEPTH] = pb;
                    wr_pos++;
                    if (wr_pos >= cap) wr_pos = 0;
                    level++;
                    if (level == cap) r.status = ST_FULL;
                end
            end
            FUNC_POP: begin
                if (level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_byte = mirror_mem[rd_pos % DEPTH];
                    rd_pos++;
                    if (rd_pos >= cap) rd_pos = 0;
                    level--;
                    if (level == 0) r.status = ST_NOW_EMPTY;
                end
            end
            FUNC_PEEK: begin
                if (level == 0) r.status = ST_EMPTY;
                else r.read_byte = mirror_mem[rd_pos % DEPTH];
            end
            FUNC_GET: begin
                if (level == 0) r.status = ST_EMPTY;
                else if (off >= level) r.status = ST_OFFSET_ERR;
                else r.read_byte = mirror_mem[((rd_pos + off) % cap) % DEPTH];
            end
            FUNC_DROP: begin
                if (level != 0) begin
                    if (nd >= level) begin
                        rd_pos = wr_pos;
                        level  = 0;
                    end else begin
                        rd_pos = (rd_pos + nd) % cap;
                        level  = level - nd;
                    end
                end
            end
            FUNC_RESET: mirror_empty();
            default: ;
        endcase
        r.fill_count = level[8:0];
        return r;
    endfunction

    // Offer one request; queue the typed result if given, else the mirror's.
    task automatic send_item(input logic [2:0] f, input logic [7:0] pb, input logic [7:0] off,
                             input logic [8:0] nd, input bit typed, input fifo_result_t want);
        fifo_result_t calc;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {7'd0, nd, off, pb};
        do @(posedge aclk); while (!s_tready);
        calc = fifo_apply(f, pb, off, nd);
        if (typed) results_due.push_back(want);
        else results_due.push_back(calc);
    endtask

    // Write the capacity only once the FIFO has returned every result.
    task automatic set_capacity(input logic [8:0] c);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_reg = 32'(c);
        mirror_empty();
    endtask

    // Random request sequences: fill bursts, drain bursts, probes, drops, noise.
    task automatic run_phase(input int budget);
        fifo_result_t none;
        int           issued;
        int           pick;
        int           n;
        int           room;
        logic [2:0]   f;
        logic [8:0]   nd;
        issued = 0;
        none   = '{ST_OK, 8'h00, 9'd0};
        while (issued < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                room = cap_now() - level;
                n = $urandom_range(1, room + 2);
                for (int k = 0; k < n && issued < budget; k++) begin
                    send_item(FUNC_PUSH, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 9'($urandom_range(0, 256)),
                              1'b0, none);
                    issued++;
                end
            end else if (pick < 50) begin
                n = $urandom_range(1, level / 2 + 2);
                for (int k = 0; k < n && issued < budget; k++) begin
                    send_item(FUNC_POP, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 9'($urandom_range(0, 256)),
                              1'b0, none);
                    issued++;
                end
            end else if (pick < 75) begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n && issued < budget; k++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_item(FUNC_PEEK, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 9'($urandom_range(0, 256)),
                                  1'b0, none);
                    end else if (level > 0 && $urandom_range(0, 9) < 8) begin
                        send_item(FUNC_GET, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, level - 1)),
                                  9'($urandom_range(0, 256)), 1'b0, none);
                    end else begin
                        send_item(FUNC_GET, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 9'($urandom_range(0, 256)),
                                  1'b0, none);
                    end
                    issued++;
                end
            end else if (pick < 85) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) nd = 9'($urandom_range(0, level));
                else if (pick < 75) nd = 9'($urandom_range(0, 256));
                else nd = 9'd256;
                send_item(FUNC_DROP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          nd, 1'b0, none);
                issued++;
            end else begin
                f = 3'($urandom_range(0, 7));
                send_item(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 256)), 1'b0, none);
                // spare codes still return a result, so they count like any item
                issued++;
            end
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off when asked.
    initial begin
        int hold_left;
        bit stall_done;
        hold_left  = 0;
        stall_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_go && !stall_done) begin
                hold_left  = 300;
                stall_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        fifo_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result: status %0d, read_byte %0h, fill_count %0d",
                       m_tuser, m_tdata[7:0], m_tdata[16:8]);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== want.read_byte) begin
                    $error("read_byte: expected %0h, actual %0h", want.read_byte, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[16:8] !== want.fill_count) begin
                    $error("fill_count: expected %0d, actual %0d", want.fill_count,
                           m_tdata[16:8]);
                    errors++;
                end
            end
        end
    end

    initial begin
        fifo_result_t want;
        int           phase_cap [8];
        int           phase_len [8];

        dir_table = '{
            '{ROW_ITEM, FUNC_POP,    8'h00, 8'h00, 9'd0,   1'b1, ST_EMPTY,      8'h00, 9'd0},
            '{ROW_ITEM, FUNC_PEEK,   8'h00, 8'h00, 9'd0,   1'b1, ST_EMPTY,      8'h00, 9'd0},
            '{ROW_ITEM, FUNC_GET,    8'h00, 8'h00, 9'd0,   1'b1, ST_EMPTY,      8'h00, 9'd0},
            '{ROW_ITEM, FUNC_DROP,   8'h00, 8'h00, 9'd5,   1'b1, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_PUSH,   8'hff, 8'h00, 9'd0,   1'b1, ST_OK,         8'h00, 9'd1},
            '{ROW_ITEM, FUNC_PUSH,   8'h00, 8'hff, 9'd256, 1'b1, ST_OK,         8'h00, 9'd2},
            '{ROW_ITEM, FUNC_PEEK,   8'h00, 8'h00, 9'd0,   1'b1, ST_OK,         8'hff, 9'd2},
            '{ROW_ITEM, FUNC_GET,    8'h00, 8'h01, 9'd0,   1'b1, ST_OK,         8'h00, 9'd2},
            '{ROW_ITEM, FUNC_GET,    8'h00, 8'h02, 9'd0,   1'b1, ST_OFFSET_ERR, 8'h00, 9'd2},
            '{ROW_ITEM, FUNC_GET,    8'h00, 8'hff, 9'd0,   1'b1, ST_OFFSET_ERR, 8'h00, 9'd2},
            '{ROW_ITEM, FUNC_SPARE6, 8'h00, 8'h00, 9'd0,   1'b1, ST_OK,         8'h00, 9'd2},
            '{ROW_ITEM, FUNC_SPARE7, 8'hff, 8'hff, 9'd256, 1'b1, ST_OK,         8'h00, 9'd2},
            '{ROW_ITEM, FUNC_POP,    8'h00, 8'h00, 9'd0,   1'b1, ST_OK,         8'hff, 9'd1},
            '{ROW_ITEM, FUNC_POP,    8'h00, 8'h00, 9'd0,   1'b1, ST_NOW_EMPTY,  8'h00, 9'd0},
            '{ROW_CFG,  FUNC_PUSH,   8'h00, 8'h00, 9'd1,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_PUSH,   8'ha5, 8'h00, 9'd0,   1'b1, ST_FULL,       8'h00, 9'd1},
            '{ROW_ITEM, FUNC_PUSH,   8'h5a, 8'h00, 9'd0,   1'b1, ST_OVERFLOW,   8'h00, 9'd1},
            '{ROW_ITEM, FUNC_GET,    8'h00, 8'h00, 9'd0,   1'b1, ST_OK,         8'ha5, 9'd1},
            '{ROW_ITEM, FUNC_POP,    8'h00, 8'h00, 9'd0,   1'b1, ST_NOW_EMPTY,  8'ha5, 9'd0},
            '{ROW_CFG,  FUNC_PUSH,   8'h00, 8'h00, 9'd3,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_PUSH,   8'h11, 8'h00, 9'd0,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_PUSH,   8'h22, 8'h00, 9'd0,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_PUSH,   8'h33, 8'h00, 9'd0,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_DROP,   8'h00, 8'h00, 9'd1,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_PUSH,   8'h44, 8'h00, 9'd0,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_GET,    8'h00, 8'h02, 9'd0,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_DROP,   8'h00, 8'h00, 9'd0,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_RESET,  8'h00, 8'h00, 9'd0,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_PUSH,   8'h66, 8'h00, 9'd0,   1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_ITEM, FUNC_DROP,   8'h00, 8'h00, 9'd256, 1'b0, ST_OK,         8'h00, 9'd0},
            '{ROW_CFG,  FUNC_PUSH,   8'h00, 8'h00, 9'd256, 1'b0, ST_OK,         8'h00, 9'd0}
        };
        phase_cap = '{256, 1, 2, 5, $urandom_range(3, 40), 255, $urandom_range(1, 256), 256};
        phase_len = '{300, 120, 120, 150, 150, 250, 150, 185};

        cap_reg = CAP_RESET;
        mirror_empty();
        send_idle_pct = 14;
        recv_idle_pct = 67;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                set_capacity(dir_table[i].drop_count);
            end else begin
                want = '{dir_table[i].status, dir_table[i].read_byte, dir_table[i].fill_count};
                send_item(dir_table[i].func, dir_table[i].push_byte, dir_table[i].offset,
                          dir_table[i].drop_count, dir_table[i].typed, want);
            end
        end

        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 67;
            end else if (p < 6) begin
                send_idle_pct = 67;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_capacity(9'(phase_cap[p]));
            // hold the receiver off while the sender keeps pushing requests
            if (p == 7) stall_go <= 1'b1;
            run_phase(phase_len[p]);
        end

        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
